// ----- rtl/core/bpmu_pkg.sv -----
// ----------------------------------------------------------------------------
// bpmu_pkg: shared types and constants of the message update block
// label count, word widths, register indexes, sequencer states and the
// request and response words of the shared arithmetic unit
// ----------------------------------------------------------------------------
package bpmu_pkg;

  // floor of log2, evaluated at elaboration only
  function automatic int flog2(input int n);
    int k;
    int m;
    k = 0;
    m = n;
    while (m > 1) begin
      m = m / 2;
      k = k + 1;
    end
    return k;
  endfunction

  localparam int NUM_LABELS = 16;
  localparam int LBL_W      = $clog2(NUM_LABELS);
  localparam int CNT_W      = 5;
  localparam int VAL_W      = 16;
  localparam int CFG_W      = 15;
  localparam int CFG_IDX_W  = 1;
  localparam int LBL_OUT_W  = 4;
  localparam int MEAN_SHIFT = flog2(NUM_LABELS);
  // room for the four-way sum and for the sum over all labels
  localparam int ALU_W      = 19 + LBL_W;

  localparam int IN_DATA_W  = 4 * VAL_W;
  localparam int OUT_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_TRUNC_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DT_SLOPE    = 1'd1;

  localparam logic [CFG_W-1:0] TRUNC_LIMIT_RST = 15'd435;
  localparam logic [CFG_W-1:0] DT_SLOPE_RST    = 15'd256;

  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic signed [ALU_W-1:0] acc_t;
  typedef logic [LBL_W-1:0]        lbl_t;
  typedef logic [CNT_W-1:0]        cnt_t;

  localparam val_t VAL_MAX = 16'sh7FFF;
  localparam val_t VAL_MIN = -16'sh8000;

  typedef struct packed {
    acc_t a;
    acc_t b;
    logic sub;
    val_t cmp;
  } alu_req_t;

  typedef struct packed {
    acc_t sum;
    val_t sat;
    val_t mn;
  } alu_rsp_t;

  typedef enum logic [14:0] {
    S_IDLE  = 15'b000000000000001,
    S_LD1   = 15'b000000000000010,
    S_LD2   = 15'b000000000000100,
    S_LD3   = 15'b000000000001000,
    S_FW_RD = 15'b000000000010000,
    S_FW_EX = 15'b000000000100000,
    S_BW_RD = 15'b000000001000000,
    S_BW_EX = 15'b000000010000000,
    S_CEIL  = 15'b000000100000000,
    S_TR_RD = 15'b000001000000000,
    S_TR_EX = 15'b000010000000000,
    S_TR_AC = 15'b000100000000000,
    S_MEAN  = 15'b001000000000000,
    S_NM_RD = 15'b010000000000000,
    S_NM_EX = 15'b100000000000000
  } state_e;

endpackage

// ----- rtl/core/bp_message_update.sv -----
// ----------------------------------------------------------------------------
// bp_message_update: belief propagation message, truncated linear cost
// loads one label per input word, then runs forward and backward distance
// transform, truncation and mean removal over the label store
// ----------------------------------------------------------------------------
// loading: each input word is accepted in the idle state, then summed in three
// accumulate steps; after the last label come forward and backward transform passes,
// a ceiling step, a truncate-and-sum pass, a mean step and a normalise pass, which
// waits on output stalls; input words are taken only in the idle state, and every
// step shares the single add/saturate/min unit and the label store's one read port
// reset: trunc_limit 435 and dt_slope 256, load count 0, running minimum 32767;
// the label store is not cleared, each entry is written before it is read
// ----------------------------------------------------------------------------
module bp_message_update (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input words: from_first, from_second, from_third, cost_here (16 bits each)
  input  logic                                s_tvalid_i,
  output logic                                s_tready_o,
  input  logic [bpmu_pkg::IN_DATA_W-1:0]      s_tdata_i,
  // result words: label_index [3:0], message_value [19:4], zero pad [23:20]
  output logic                                m_tvalid_o,
  input  logic                                m_tready_i,
  output logic [bpmu_pkg::OUT_DATA_W-1:0]     m_tdata_o,
  output logic                                m_tlast_o,    // final_label
  // configuration writes
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [bpmu_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [bpmu_pkg::CFG_W-1:0]          cfg_data_i
);

  localparam bpmu_pkg::lbl_t LAST_IDX = bpmu_pkg::LBL_W'(bpmu_pkg::NUM_LABELS - 1);
  localparam bpmu_pkg::cnt_t LAST_CNT = bpmu_pkg::CNT_W'(bpmu_pkg::NUM_LABELS - 1);

  // control state
  bpmu_pkg::state_e state_q, state_d;
  bpmu_pkg::cnt_t   cnt_q, cnt_d;        // labels loaded so far
  bpmu_pkg::lbl_t   idx_q, idx_d;        // pass pointer
  bpmu_pkg::val_t   min_q, min_d;        // running minimum of the loaded sums
  logic             out_valid_q, out_valid_d;
  logic [bpmu_pkg::CFG_W-1:0] trunc_q, slope_q;

  // payload
  bpmu_pkg::val_t   fld_q [4];
  bpmu_pkg::val_t   fld_d [4];
  bpmu_pkg::acc_t   acc_q, acc_d;        // four-way sum while loading, total while truncating
  bpmu_pkg::val_t   prev_q, prev_d;      // neighbour value in the transform, truncated value
  bpmu_pkg::val_t   ceil_q, ceil_d;
  bpmu_pkg::acc_t   mean_q, mean_d;
  logic [bpmu_pkg::LBL_OUT_W-1:0] out_lbl_q, out_lbl_d;
  bpmu_pkg::val_t   out_val_q, out_val_d;
  logic             out_last_q, out_last_d;

  // shared unit and label store
  bpmu_pkg::alu_req_t alu_req;
  bpmu_pkg::alu_rsp_t alu_rsp;
  logic               ram_we;
  bpmu_pkg::lbl_t     ram_waddr;
  bpmu_pkg::val_t     ram_wdata;
  logic [bpmu_pkg::VAL_W-1:0] ram_rdata;
  bpmu_pkg::val_t     rd_val;

  logic s_fire;
  logic out_free;

  assign s_tready_o  = (state_q == bpmu_pkg::S_IDLE);
  assign s_fire      = s_tvalid_i && s_tready_o;
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || m_tready_i;
  assign rd_val      = bpmu_pkg::val_t'(ram_rdata);

  bpmu_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  bpmu_ram #(
    .WIDTH (bpmu_pkg::VAL_W),
    .DEPTH (bpmu_pkg::NUM_LABELS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  // operand selection for the shared unit
  always_comb begin
    alu_req.a   = '0;
    alu_req.b   = '0;
    alu_req.sub = 1'b0;
    alu_req.cmp = bpmu_pkg::VAL_MAX;
    case (state_q)
      bpmu_pkg::S_LD1: begin
        alu_req.a = bpmu_pkg::acc_t'(fld_q[0]);
        alu_req.b = bpmu_pkg::acc_t'(fld_q[1]);
      end
      bpmu_pkg::S_LD2: begin
        alu_req.a = acc_q;
        alu_req.b = bpmu_pkg::acc_t'(fld_q[2]);
      end
      bpmu_pkg::S_LD3: begin
        alu_req.a   = acc_q;
        alu_req.b   = bpmu_pkg::acc_t'(fld_q[3]);
        alu_req.cmp = min_q;
      end
      bpmu_pkg::S_FW_EX, bpmu_pkg::S_BW_EX: begin
        // candidate from the neighbour, kept only if strictly smaller
        alu_req.a   = bpmu_pkg::acc_t'(prev_q);
        alu_req.b   = bpmu_pkg::acc_t'(slope_q);
        alu_req.cmp = rd_val;
      end
      bpmu_pkg::S_CEIL: begin
        alu_req.a = bpmu_pkg::acc_t'(min_q);
        alu_req.b = bpmu_pkg::acc_t'(trunc_q);
      end
      bpmu_pkg::S_TR_EX: begin
        alu_req.a   = bpmu_pkg::acc_t'(rd_val);
        alu_req.cmp = ceil_q;
      end
      bpmu_pkg::S_TR_AC: begin
        alu_req.a = acc_q;
        alu_req.b = bpmu_pkg::acc_t'(prev_q);
      end
      bpmu_pkg::S_NM_EX: begin
        alu_req.a   = bpmu_pkg::acc_t'(rd_val);
        alu_req.b   = mean_q;
        alu_req.sub = 1'b1;
      end
      default: begin
        alu_req.a = '0;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    min_d       = min_q;
    out_valid_d = out_valid_q && !m_tready_i;
    fld_d       = fld_q;
    acc_d       = acc_q;
    prev_d      = prev_q;
    ceil_d      = ceil_q;
    mean_d      = mean_q;
    out_lbl_d   = out_lbl_q;
    out_val_d   = out_val_q;
    out_last_d  = out_last_q;
    ram_we      = 1'b0;
    ram_waddr   = idx_q;
    ram_wdata   = alu_rsp.mn;

    case (state_q)
      bpmu_pkg::S_IDLE: begin
        if (s_fire) begin
          fld_d[0] = bpmu_pkg::val_t'(s_tdata_i[15:0]);
          fld_d[1] = bpmu_pkg::val_t'(s_tdata_i[31:16]);
          fld_d[2] = bpmu_pkg::val_t'(s_tdata_i[47:32]);
          fld_d[3] = bpmu_pkg::val_t'(s_tdata_i[63:48]);
          state_d  = bpmu_pkg::S_LD1;
        end
      end
      bpmu_pkg::S_LD1: begin
        acc_d   = alu_rsp.sum;
        state_d = bpmu_pkg::S_LD2;
      end
      bpmu_pkg::S_LD2: begin
        acc_d   = alu_rsp.sum;
        state_d = bpmu_pkg::S_LD3;
      end
      bpmu_pkg::S_LD3: begin
        // saturated sum into the store, minimum tracked alongside
        ram_we    = 1'b1;
        ram_waddr = cnt_q[bpmu_pkg::LBL_W-1:0];
        ram_wdata = alu_rsp.sat;
        min_d     = alu_rsp.mn;
        if (cnt_q == LAST_CNT) begin
          cnt_d   = '0;
          idx_d   = '0;
          state_d = bpmu_pkg::S_FW_RD;
        end else begin
          cnt_d   = cnt_q + 1'b1;
          state_d = bpmu_pkg::S_IDLE;
        end
      end
      bpmu_pkg::S_FW_RD: begin
        state_d = bpmu_pkg::S_FW_EX;
      end
      bpmu_pkg::S_FW_EX: begin
        if (idx_q == '0) begin
          prev_d = rd_val;
        end else begin
          ram_we = 1'b1;
          prev_d = alu_rsp.mn;
        end
        if (idx_q == LAST_IDX) begin
          state_d = bpmu_pkg::S_BW_RD;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = bpmu_pkg::S_FW_RD;
        end
      end
      bpmu_pkg::S_BW_RD: begin
        state_d = bpmu_pkg::S_BW_EX;
      end
      bpmu_pkg::S_BW_EX: begin
        if (idx_q == LAST_IDX) begin
          prev_d = rd_val;
        end else begin
          ram_we = 1'b1;
          prev_d = alu_rsp.mn;
        end
        if (idx_q == '0) begin
          state_d = bpmu_pkg::S_CEIL;
        end else begin
          idx_d   = idx_q - 1'b1;
          state_d = bpmu_pkg::S_BW_RD;
        end
      end
      bpmu_pkg::S_CEIL: begin
        ceil_d  = alu_rsp.sat;
        acc_d   = '0;
        idx_d   = '0;
        state_d = bpmu_pkg::S_TR_RD;
      end
      bpmu_pkg::S_TR_RD: begin
        state_d = bpmu_pkg::S_TR_EX;
      end
      bpmu_pkg::S_TR_EX: begin
        ram_we  = 1'b1;
        prev_d  = alu_rsp.mn;
        state_d = bpmu_pkg::S_TR_AC;
      end
      bpmu_pkg::S_TR_AC: begin
        acc_d = alu_rsp.sum;
        if (idx_q == LAST_IDX) begin
          state_d = bpmu_pkg::S_MEAN;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = bpmu_pkg::S_TR_RD;
        end
      end
      bpmu_pkg::S_MEAN: begin
        // arithmetic shift rounds toward minus infinity
        mean_d  = acc_q >>> bpmu_pkg::MEAN_SHIFT;
        idx_d   = '0;
        state_d = bpmu_pkg::S_NM_RD;
      end
      bpmu_pkg::S_NM_RD: begin
        state_d = bpmu_pkg::S_NM_EX;
      end
      bpmu_pkg::S_NM_EX: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_lbl_d   = bpmu_pkg::LBL_OUT_W'(idx_q);
          out_val_d   = alu_rsp.sat;
          out_last_d  = (idx_q == LAST_IDX);
          if (idx_q == LAST_IDX) begin
            min_d   = bpmu_pkg::VAL_MAX;
            idx_d   = '0;
            state_d = bpmu_pkg::S_IDLE;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = bpmu_pkg::S_NM_RD;
          end
        end
      end
      default: begin
        state_d = bpmu_pkg::S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bpmu_pkg::S_IDLE;
      cnt_q       <= '0;
      idx_q       <= '0;
      min_q       <= bpmu_pkg::VAL_MAX;
      out_valid_q <= 1'b0;
      trunc_q     <= bpmu_pkg::TRUNC_LIMIT_RST;
      slope_q     <= bpmu_pkg::DT_SLOPE_RST;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      min_q       <= min_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          bpmu_pkg::REG_TRUNC_LIMIT: trunc_q <= cfg_data_i;
          bpmu_pkg::REG_DT_SLOPE:    slope_q <= cfg_data_i;
          default: begin
            trunc_q <= trunc_q;
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    fld_q      <= fld_d;
    acc_q      <= acc_d;
    prev_q     <= prev_d;
    ceil_q     <= ceil_d;
    mean_q     <= mean_d;
    out_lbl_q  <= out_lbl_d;
    out_val_q  <= out_val_d;
    out_last_q <= out_last_d;
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {4'b0000, out_val_q, out_lbl_q};
  assign m_tlast_o  = out_last_q;

  // checks
  a_load_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> state_q == bpmu_pkg::S_LD1)
    else $error("accepted word did not start the load sequence");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_tvalid_o) |-> $past(state_q == bpmu_pkg::S_NM_EX))
    else $error("result word raised outside the normalise step");

  a_last_label: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && m_tlast_o) |->
      m_tdata_o[bpmu_pkg::LBL_OUT_W-1:0] == bpmu_pkg::LBL_OUT_W'(bpmu_pkg::NUM_LABELS - 1))
    else $error("final label flag on the wrong label");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bpmu_pkg::S_NM_EX && !m_tvalid_o) |=> m_tvalid_o)
    else $error("normalise step did not fill an empty output register");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= LAST_CNT)
    else $error("load count beyond the label count");

endmodule

// ----- rtl/core/bpmu_ram.sv -----
// ----------------------------------------------------------------------------
// bpmu_ram: generic single-port-write, single-port-read RAM
// one write and one registered read per cycle, contents not reset
// ----------------------------------------------------------------------------
module bpmu_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- rtl/core/bpmu_alu.sv -----
// ----------------------------------------------------------------------------
// bpmu_alu: shared add, saturate and minimum unit
// wide add or subtract, clamp to signed 16 bits, then minimum with a compare word
// ----------------------------------------------------------------------------
module bpmu_alu (
  input  bpmu_pkg::alu_req_t req_i,
  output bpmu_pkg::alu_rsp_t rsp_o
);

  localparam bpmu_pkg::acc_t SAT_HI = bpmu_pkg::acc_t'(32767);
  localparam bpmu_pkg::acc_t SAT_LO = bpmu_pkg::acc_t'(-32768);

  bpmu_pkg::acc_t b_eff;
  bpmu_pkg::acc_t sum;
  bpmu_pkg::val_t sat;

  assign b_eff = req_i.sub ? -req_i.b : req_i.b;
  assign sum   = req_i.a + b_eff;

  always_comb begin
    if (sum > SAT_HI) begin
      sat = bpmu_pkg::VAL_MAX;
    end else if (sum < SAT_LO) begin
      sat = bpmu_pkg::VAL_MIN;
    end else begin
      sat = bpmu_pkg::val_t'(sum[bpmu_pkg::VAL_W-1:0]);
    end
  end

  assign rsp_o.sum = sum;
  assign rsp_o.sat = sat;
  assign rsp_o.mn  = (sat < req_i.cmp) ? sat : req_i.cmp;

endmodule

// ----- dv/bp_message_update_check.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bp_message_update_check: result checker for the message update block
// follows the input, result and register channels, keeps its own copy of the
// label sums and settings, works out each outgoing message and compares it
// word by word with what the block sends
// ----------------------------------------------------------------------------
module bp_message_update_check
  import bpmu_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_tvalid_i,
  input  logic                  s_tready_i,
  input  logic [IN_DATA_W-1:0]  s_tdata_i,
  input  logic                  m_tvalid_i,
  input  logic                  m_tready_i,
  input  logic [OUT_DATA_W-1:0] m_tdata_i,
  input  logic                  m_tlast_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_W-1:0]      cfg_data_i,
  output int                    fail_count_o,
  output int                    words_due_o
);

  typedef struct {
    logic [LBL_OUT_W-1:0] label;
    val_t                 value;
    logic                 last;
  } msg_word_t;

  logic [CFG_W-1:0] trunc_q;
  logic [CFG_W-1:0] slope_q;
  val_t             belief [NUM_LABELS];
  val_t             floor_q;
  int               loaded_q;
  msg_word_t        words_due [$];

  function automatic val_t clip16(input longint v);
    if (v > 32767) return VAL_MAX;
    if (v < -32768) return VAL_MIN;
    return val_t'(v);
  endfunction

  // distance transform both ways, truncation, mean removal
  function automatic void build_message();
    val_t   cand;
    val_t   ceiling;
    longint total;
    longint mean;
    total = 0;
    for (int q = 1; q < NUM_LABELS; q++) begin
      cand = clip16(longint'(belief[q-1]) + longint'(slope_q));
      if (cand < belief[q]) belief[q] = cand;
    end
    for (int q = NUM_LABELS - 1; q > 0; q--) begin
      cand = clip16(longint'(belief[q]) + longint'(slope_q));
      if (cand < belief[q-1]) belief[q-1] = cand;
    end
    ceiling = clip16(longint'(floor_q) + longint'(trunc_q));
    for (int q = 0; q < NUM_LABELS; q++) begin
      if (ceiling < belief[q]) belief[q] = ceiling;
      total += belief[q];
    end
    mean = total >>> MEAN_SHIFT;
    for (int q = 0; q < NUM_LABELS; q++) begin
      words_due.push_back('{label: LBL_OUT_W'(q),
                            value: clip16(longint'(belief[q]) - mean),
                            last:  (q == NUM_LABELS - 1)});
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    longint    acc;
    msg_word_t exp_w;
    if (!rst_ni) begin
      trunc_q      = TRUNC_LIMIT_RST;
      slope_q      = DT_SLOPE_RST;
      floor_q      = VAL_MAX;
      loaded_q     = 0;
      fail_count_o = 0;
      words_due.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_TRUNC_LIMIT: trunc_q = cfg_data_i;
          REG_DT_SLOPE:    slope_q = cfg_data_i;
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i) begin
        acc = longint'($signed(s_tdata_i[15:0])) + longint'($signed(s_tdata_i[31:16]))
            + longint'($signed(s_tdata_i[47:32])) + longint'($signed(s_tdata_i[63:48]));
        belief[loaded_q] = clip16(acc);
        if (belief[loaded_q] < floor_q) floor_q = belief[loaded_q];
        loaded_q++;
        if (loaded_q == NUM_LABELS) begin
          build_message();
          loaded_q = 0;
          floor_q  = VAL_MAX;
        end
      end
      if (m_tvalid_i && m_tready_i) begin
        if (words_due.size() == 0) begin
          $error("result word with nothing expected: label_index %0d message_value %0d",
                 m_tdata_i[3:0], $signed(m_tdata_i[19:4]));
          fail_count_o++;
        end else begin
          exp_w = words_due.pop_front();
          if (m_tdata_i[3:0] !== exp_w.label) begin
            $error("label_index expected %0d got %0d", exp_w.label, m_tdata_i[3:0]);
            fail_count_o++;
          end
          if ($signed(m_tdata_i[19:4]) !== exp_w.value) begin
            $error("message_value expected %0d got %0d", exp_w.value,
                   $signed(m_tdata_i[19:4]));
            fail_count_o++;
          end
          if (m_tlast_i !== exp_w.last) begin
            $error("final_label expected %0d got %0d", exp_w.last, m_tlast_i);
            fail_count_o++;
          end
        end
      end
    end
    words_due_o = words_due.size();
  end

endmodule

// ----- dv/bp_message_update_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bp_message_update_test: stimulus and verdict for the message update block
// one directed message of extreme label words, then random messages over a
// run of register settings, with random gaps on both channels and one long
// hold-off on the result side; the checker beside the block does the compare
// ----------------------------------------------------------------------------
module bp_message_update_test;
  import bpmu_pkg::*;

  localparam int STALL_LIMIT = 2500;  // cycles with no handshake on any channel
  localparam int LONG_HOLD   = 400;   // result side hold-off, fills the block
  localparam int DRAIN_WAIT  = 160;   // a bit over one full message latency

  // shapes of label data inside one random message
  typedef enum int {
    STYLE_WIDE,    // any 16-bit value in every field
    STYLE_NARROW,  // small values around zero
    STYLE_RAMP,    // v-shaped cost curve, the usual case for a real pixel
    STYLE_FLAT,    // same value on every label, ties everywhere
    STYLE_EDGE     // values at or near the ends of the range
  } shape_e;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata   = '0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_TRUNC_LIMIT;
  logic [CFG_W-1:0]      cfg_data  = '0;

  int fail_count;
  int words_due;
  int quiet_cycles = 0;

  // gap switches for the two sides, and the one-off long hold request
  bit tx_idle  = 1'b1;
  bit rx_idle  = 1'b1;
  bit hold_req = 1'b0;

  always #6 clk = ~clk;

  bp_message_update dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .s_tvalid_i  (s_tvalid),
    .s_tready_o  (s_tready),
    .s_tdata_i   (s_tdata),    // from_first, from_second, from_third, cost_here
    .m_tvalid_o  (m_tvalid),
    .m_tready_i  (m_tready),
    .m_tdata_o   (m_tdata),    // label_index, message_value, zero pad
    .m_tlast_o   (m_tlast),    // final_label
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  bp_message_update_check checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .m_tlast_i    (m_tlast),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .words_due_o  (words_due)
  );

  // watchdog: any accepted word on any channel counts as progress
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("bp_message_update_test NOT OK");
      $finish;
    end
  end

  // result side: ready by default, random stall bursts, and one long hold
  // counted here while the sender keeps offering words
  initial begin
    bit held;
    held = 1'b0;
    m_tready <= 1'b1;
    forever begin
      @(negedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        m_tready <= 1'b1;
      end else if (rx_idle && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk);
        m_tready <= 1'b1;
      end
    end
  end

  // offers one label word, maybe after a gap; tvalid stays high on return
  // so a following word goes out back to back
  task automatic send_word(input logic [IN_DATA_W-1:0] w);
    if (tx_idle && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= w;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // both registers, back to back, only while the block is idle
  task automatic write_regs(input logic [CFG_W-1:0] trunc_v, input logic [CFG_W-1:0] slope_v);
    cfg_valid <= 1'b1;
    cfg_index <= REG_TRUNC_LIMIT;
    cfg_data  <= trunc_v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_index <= REG_DT_SLOPE;
    cfg_data  <= slope_v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [VAL_W-1:0] pick_value(input shape_e shape, input int lbl,
                                                  input int base, input int step,
                                                  input int centre);
    int d;
    d = lbl - centre;
    if (d < 0) d = -d;
    case (shape)
      STYLE_WIDE:   return VAL_W'($urandom);
      STYLE_NARROW: return VAL_W'(int'($urandom_range(0, 1024)) - 512);
      STYLE_RAMP:   return VAL_W'(base + step * d + int'($urandom_range(0, 64)) - 32);
      STYLE_FLAT:   return VAL_W'(base);
      default: begin
        case ($urandom_range(0, 3))
          0:       return 16'h7FFF;
          1:       return 16'h8000;
          2:       return VAL_W'(32'h7FFF - $urandom_range(0, 255));
          default: return VAL_W'(32'h8000 + $urandom_range(0, 255));
        endcase
      end
    endcase
  endfunction

  // one whole message of random label words in a shape chosen per message
  task automatic send_message();
    int                   r;
    int                   base;
    int                   step;
    int                   centre;
    shape_e               shape;
    logic [IN_DATA_W-1:0] w;
    r      = $urandom_range(0, 9);
    base   = int'($urandom_range(0, 4000)) - 2000;
    step   = $urandom_range(0, 400);
    centre = $urandom_range(0, NUM_LABELS - 1);
    if (r < 2)      shape = STYLE_WIDE;
    else if (r < 5) shape = STYLE_NARROW;
    else if (r < 8) shape = STYLE_RAMP;
    else if (r < 9) shape = STYLE_FLAT;
    else            shape = STYLE_EDGE;
    for (int lbl = 0; lbl < NUM_LABELS; lbl++) begin
      w = {pick_value(shape, lbl, base, step, centre), pick_value(shape, lbl, base, step, centre),
           pick_value(shape, lbl, base, step, centre), pick_value(shape, lbl, base, step, centre)};
      send_word(w);
    end
  endtask

  // phases always end on a message boundary, so the block is idle once the
  // last result word is out; a short pause covers any trailing housekeeping
  task automatic drain();
    s_tvalid <= 1'b0;
    while (words_due != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic run_phase(input int n_msgs);
    for (int i = 0; i < n_msgs; i++) send_message();
    drain();
  endtask

  initial begin
    logic [IN_DATA_W-1:0] directed [NUM_LABELS];

    // directed message: saturation of the four-way sum both ways, single
    // extreme fields, cancelling extremes, small equal fields, then pairs of tied labels
    directed[0] = {4{16'h7FFF}};
    directed[1] = {4{16'h8000}};
    directed[2] = {48'h0, 16'h7FFF};
    directed[3] = {16'h8000, 48'h0};
    directed[4] = {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000};
    directed[5] = {4{16'hFFFF}};
    directed[6] = {4{16'h0001}};
    directed[7] = {16'h0000, 16'h8000, 16'h0000, 16'h7FFF};
    for (int l = 8; l < NUM_LABELS; l++) begin
      directed[l] = {VAL_W'(256 * (l / 2)), 48'h0};
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings, no register write yet
    for (int l = 0; l < NUM_LABELS; l++) send_word(directed[l]);
    run_phase(3);

    // no slope and no truncation margin
    write_regs('0, '0);
    run_phase(4);

    // both at their maximum
    write_regs('1, '1);
    run_phase(4);

    // anywhere in the range
    write_regs(CFG_W'($urandom), CFG_W'($urandom));
    run_phase(4);

    // long hold on the result side while words keep coming
    write_regs(CFG_W'($urandom_range(0, 1200)), CFG_W'($urandom_range(0, 512)));
    hold_req = 1'b1;
    run_phase(4);

    // smallest non-zero steps, back to back on both sides
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    write_regs(CFG_W'(1), CFG_W'(1));
    run_phase(4);
    tx_idle = 1'b1;
    rx_idle = 1'b1;

    // back to the usual stereo settings
    write_regs(TRUNC_LIMIT_RST, DT_SLOPE_RST);
    run_phase(4);

    // last part runs without gaps
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    write_regs(CFG_W'($urandom_range(0, 2000)), CFG_W'($urandom_range(0, 600)));
    run_phase(4);

    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0) begin
      $display("bp_message_update_test OK");
    end else begin
      $display("bp_message_update_test NOT OK");
    end
    $finish;
  end

endmodule
